// ===== rtl/ipm_pkg.sv =====
// Shared constants for the image PSNR meter.
package ipm_pkg;

  localparam int CfgW      = 11;
  localparam int SideRst   = 512;
  localparam int PixW      = 8;
  localparam int SumW      = 36;
  localparam int MseW      = 24;
  localparam int PsnrW     = 15;
  localparam int PeakSq    = 65025;
  localparam int LogFrac   = 24;
  localparam int MantBits  = 30;
  localparam int LogW      = 40;
  localparam int ExpW      = 6;
  localparam int MulW      = 32;
  localparam int PaddrW    = 3;
  localparam int PdataW    = 32;
  localparam int RegIdxW   = PaddrW - 2;

  localparam logic [MulW-1:0]    TenLog2Q28 = 32'd808071242;
  localparam logic [PsnrW-1:0]   PsnrMax    = '1;
  localparam logic [RegIdxW-1:0] RegSide    = '0;

  localparam int MaxSideDef  = 1024;
  localparam int FracBitsDef = 8;

endpackage

// ===== rtl/ipm_mul.sv =====
// Shared multiplier with registered product.
module ipm_mul
  import ipm_pkg::*;
(
  input  logic                clk_i,
  input  logic [MulW-1:0]     a_i,
  input  logic [MulW-1:0]     b_i,
  output logic [2*MulW-1:0]   p_o
);

  logic [2*MulW-1:0] prod;
  logic [2*MulW-1:0] p_q;

  assign prod = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= prod;
  end

  assign p_o = p_q;

endmodule

// ===== rtl/ipm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ipm_div #(
  parameter int DVD_W = 44,
  parameter int DSR_W = 22
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CntW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q;
  logic [DSR_W-1:0] rem_q;
  logic [DSR_W-1:0] dsr_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;

  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   rem_sub;
  logic             qbit;
  logic [DSR_W-1:0] rem_n;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    qbit    = (rem_sh >= {1'b0, dsr_q});
    rem_n   = qbit ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
      cnt_q  <= CntW'(DVD_W);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], qbit};
      rem_q <= rem_n;
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/ipm_cfg.sv =====
// APB register file holding the image side.
module ipm_cfg
  import ipm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output logic [CfgW-1:0]   side_o
);

  logic [CfgW-1:0]    side_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;

  assign reg_idx = paddr[PaddrW-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= CfgW'(SideRst);
    end else if (wr_en && reg_idx == RegSide) begin
      side_q <= pwdata[CfgW-1:0];
    end
  end

  assign prdata = (reg_idx == RegSide) ? PdataW'(side_q) : '0;
  assign pready = 1'b1;
  assign side_o = side_q;

endmodule

// ===== rtl/image_psnr_meter.sv =====
// Top level of the image PSNR meter: pixel accumulator and result sequencer.
//
// Usage: pixel pairs enter on the input channel (in_valid_i / in_stall_o),
// one beat per cycle, in raster order. Each beat adds (ref - test)^2 to a
// saturating 36-bit accumulator. The beat with last_pixel_i set closes the
// image: the block stalls its input and runs the result sequence, then puts
// one result beat (error sum, MSE, PSNR, infinite flag) on the output channel
// (out_valid_o / out_stall_i) and takes pixels again.
// Throughput: one pixel per cycle inside an image. After the last beat the
// sequence length depends on the top set bit positions of 65025*side^2 and
// of the sum (shorter for identical images, where the second log2 is
// skipped); it is set by the shared 32x32 multiplier doing 24 squarings per
// log2, each through S_SQ and S_SQF, plus a one-bit-per-cycle normalizing
// shift. The MSE divider runs alongside.
// A result waiting under out_stall_i does not block the next image's pixels;
// only a second finished result waits until the first is taken.
// Reset clears the accumulator and any pending result and sets image_side to
// 512. The user writes image_side through the APB port only while idle; the block does not enforce it.
module image_psnr_meter
  import ipm_pkg::*;
#(
  parameter int MAX_SIDE  = MaxSideDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [PixW-1:0]   pixel_ref_i,
  input  logic [PixW-1:0]   pixel_test_i,
  input  logic              last_pixel_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SumW-1:0]   squared_error_sum_o,
  output logic [MseW-1:0]   mse_value_o,
  output logic [PsnrW-1:0]  psnr_db_o,
  output logic              psnr_infinite_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int SideClog = $clog2(MAX_SIDE + 1);
  localparam int SideW    = (SideClog < CfgW) ? SideClog : CfgW;
  localparam int NpixW    = 2 * SideW;
  localparam int DvdW     = SumW + FRAC_BITS;
  localparam int PsnrSh   = LogFrac + 28 - FRAC_BITS;
  localparam int LqW      = ExpW + LogFrac;
  localparam int RndW     = $clog2(LogFrac);
  localparam int MantW    = MantBits + 1;
  localparam logic [DvdW-1:0] MseCap = DvdW'(PeakSq) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_NPIX, S_NPK, S_NPK2, S_LOADN, S_NORM, S_SQ, S_SQF,
    S_DIFF, S_PSN, S_WAIT
  } state_e;

  // configuration
  logic [CfgW-1:0] side_cfg;
  logic [SideW-1:0] side_eff;

  ipm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .side_o  (side_cfg)
  );

  always_comb begin
    if (side_cfg == '0) begin
      side_eff = SideW'(1);
    end else if (32'(side_cfg) > MAX_SIDE) begin
      side_eff = SideW'(MAX_SIDE);
    end else begin
      side_eff = side_cfg[SideW-1:0];
    end
  end

  // registers
  state_e              state_q, state_d;
  logic [SumW-1:0]     acc_q, acc_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [NpixW-1:0]    npix_q, npix_d;
  logic [LogW-1:0]     lx_q, lx_d;
  logic [ExpW-1:0]     cnt_q, cnt_d;
  logic [ExpW-1:0]     exp_q, exp_d;
  logic [MantW-1:0]    mant_q, mant_d;
  logic [LogFrac-1:0]  frac_q, frac_d;
  logic [RndW-1:0]     rnd_q, rnd_d;
  logic                lsel_q, lsel_d;
  logic [LqW-1:0]      ln_q, ln_d;
  logic [LqW-1:0]      ld_q, ld_d;
  logic [PsnrW-1:0]    psnr_q, psnr_d;
  logic                ovld_q, ovld_d;
  logic [SumW-1:0]     osum_q, osum_d;
  logic [MseW-1:0]     omse_q, omse_d;
  logic [PsnrW-1:0]    opsnr_q, opsnr_d;
  logic                oinf_q, oinf_d;

  // accumulate path
  logic                  in_acc;
  logic [PixW-1:0]       diff;
  logic [2*PixW-1:0]     sq;
  logic [SumW:0]         acc_sum;
  logic [SumW-1:0]       acc_sat;

  assign in_acc = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    diff    = (pixel_ref_i >= pixel_test_i) ? (pixel_ref_i - pixel_test_i)
                                            : (pixel_test_i - pixel_ref_i);
    sq      = diff * diff;
    acc_sum = {1'b0, acc_q} + (SumW + 1)'(sq);
    acc_sat = acc_sum[SumW] ? '1 : acc_sum[SumW-1:0];
  end

  // shared multiplier
  logic [MulW-1:0]   mul_a, mul_b;
  logic [2*MulW-1:0] mul_p;
  logic [LqW-1:0]    ldiff;

  assign ldiff = (ln_q > ld_q) ? (ln_q - ld_q) : '0;

  always_comb begin
    case (state_q)
      S_NPIX: begin
        mul_a = MulW'(side_eff);
        mul_b = MulW'(side_eff);
      end
      S_NPK2: begin
        mul_a = MulW'(PeakSq);
        mul_b = MulW'(npix_q);
      end
      S_SQ: begin
        mul_a = MulW'(mant_q);
        mul_b = MulW'(mant_q);
      end
      S_DIFF: begin
        mul_a = MulW'(ldiff);
        mul_b = TenLog2Q28;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ipm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // MSE divider
  logic            div_start;
  logic            div_busy;
  logic [DvdW-1:0] div_quo;
  logic [DvdW-1:0] mse_full;

  assign div_start = (state_q == S_NPK2);
  assign mse_full  = (div_quo > MseCap) ? MseCap : div_quo;

  ipm_div #(
    .DVD_W (DvdW),
    .DSR_W (NpixW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_q, FRAC_BITS'(0)}),
    .divisor_i  (npix_q),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // squaring step of the log2
  logic [MantBits+1:0] m2;
  logic                fbit;
  logic [LogFrac-1:0]  frac_n;
  logic [2*MulW-1:0]   psnr_sh;

  always_comb begin
    m2      = mul_p[2*MantBits+1:MantBits];
    fbit    = m2[MantBits+1];
    frac_n  = {frac_q[LogFrac-2:0], fbit};
    psnr_sh = mul_p >> PsnrSh;
  end

  logic out_free;
  assign out_free = !ovld_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    sum_d   = sum_q;
    npix_d  = npix_q;
    lx_d    = lx_q;
    cnt_d   = cnt_q;
    exp_d   = exp_q;
    mant_d  = mant_q;
    frac_d  = frac_q;
    rnd_d   = rnd_q;
    lsel_d  = lsel_q;
    ln_d    = ln_q;
    ld_d    = ld_q;
    psnr_d  = psnr_q;
    ovld_d  = ovld_q && out_stall_i;
    osum_d  = osum_q;
    omse_d  = omse_q;
    opsnr_d = opsnr_q;
    oinf_d  = oinf_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (last_pixel_i) begin
            sum_d   = acc_sat;
            acc_d   = '0;
            psnr_d  = '0;
            state_d = S_NPIX;
          end else begin
            acc_d = acc_sat;
          end
        end
      end
      S_NPIX: begin
        state_d = S_NPK;
      end
      S_NPK: begin
        npix_d  = mul_p[NpixW-1:0];
        state_d = S_NPK2;
      end
      S_NPK2: begin
        state_d = S_LOADN;
      end
      S_LOADN: begin
        lx_d    = mul_p[LogW-1:0];
        cnt_d   = '0;
        lsel_d  = 1'b0;
        state_d = S_NORM;
      end
      S_NORM: begin
        if (lx_q[LogW-1]) begin
          mant_d  = lx_q[LogW-1 -: MantW];
          exp_d   = ExpW'(LogW - 1) - cnt_q;
          frac_d  = '0;
          rnd_d   = '0;
          state_d = S_SQ;
        end else begin
          lx_d  = {lx_q[LogW-2:0], 1'b0};
          cnt_d = cnt_q + ExpW'(1);
        end
      end
      S_SQ: begin
        state_d = S_SQF;
      end
      S_SQF: begin
        frac_d = frac_n;
        mant_d = fbit ? m2[MantBits+1:1] : m2[MantBits:0];
        rnd_d  = rnd_q + RndW'(1);
        if (rnd_q == RndW'(LogFrac - 1)) begin
          if (!lsel_q) begin
            ln_d = {exp_q, frac_n};
            if (sum_q == '0) begin
              state_d = S_WAIT;
            end else begin
              lx_d    = LogW'(sum_q);
              cnt_d   = '0;
              lsel_d  = 1'b1;
              state_d = S_NORM;
            end
          end else begin
            ld_d    = {exp_q, frac_n};
            state_d = S_DIFF;
          end
        end else begin
          state_d = S_SQ;
        end
      end
      S_DIFF: begin
        state_d = S_PSN;
      end
      S_PSN: begin
        psnr_d  = (psnr_sh > (2*MulW)'(PsnrMax)) ? PsnrMax : psnr_sh[PsnrW-1:0];
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (!div_busy && out_free) begin
          ovld_d  = 1'b1;
          osum_d  = sum_q;
          omse_d  = mse_full[MseW-1:0];
          opsnr_d = psnr_q;
          oinf_d  = (sum_q == '0);
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q   <= '0;
      sum_q   <= '0;
      npix_q  <= '0;
      lx_q    <= '0;
      cnt_q   <= '0;
      exp_q   <= '0;
      mant_q  <= '0;
      frac_q  <= '0;
      rnd_q   <= '0;
      lsel_q  <= 1'b0;
      ln_q    <= '0;
      ld_q    <= '0;
      psnr_q  <= '0;
      ovld_q  <= 1'b0;
      osum_q  <= '0;
      omse_q  <= '0;
      opsnr_q <= '0;
      oinf_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      sum_q   <= sum_d;
      npix_q  <= npix_d;
      lx_q    <= lx_d;
      cnt_q   <= cnt_d;
      exp_q   <= exp_d;
      mant_q  <= mant_d;
      frac_q  <= frac_d;
      rnd_q   <= rnd_d;
      lsel_q  <= lsel_d;
      ln_q    <= ln_d;
      ld_q    <= ld_d;
      psnr_q  <= psnr_d;
      ovld_q  <= ovld_d;
      osum_q  <= osum_d;
      omse_q  <= omse_d;
      opsnr_q <= opsnr_d;
      oinf_q  <= oinf_d;
    end
  end

  assign in_stall_o          = (state_q != S_IDLE);
  assign out_valid_o         = ovld_q;
  assign squared_error_sum_o = osum_q;
  assign mse_value_o         = omse_q;
  assign psnr_db_o           = opsnr_q;
  assign psnr_infinite_o     = oinf_q;

endmodule

// ===== rtl/ipm_checker.sv =====
// Port-level assertions for the image PSNR meter, bound to the top level.
module ipm_checker
  import ipm_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             last_pixel_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [SumW-1:0]  squared_error_sum_o,
  input logic [MseW-1:0]  mse_value_o,
  input logic [PsnrW-1:0] psnr_db_o,
  input logic             psnr_infinite_o
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(squared_error_sum_o) && $stable(psnr_db_o))
    else $error("stalled result changed");

  a_inf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && psnr_infinite_o |->
      squared_error_sum_o == '0 && psnr_db_o == '0 && mse_value_o == '0)
    else $error("infinite flag with nonzero fields");

  a_finite_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !psnr_infinite_o |-> squared_error_sum_o != '0)
    else $error("zero sum without infinite flag");

  // the closing beat starts the result sequence
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_pixel_i |=> in_stall_o)
    else $error("input not stalled after last beat");

endmodule

bind image_psnr_meter ipm_checker u_ipm_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .last_pixel_i        (last_pixel_i),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .squared_error_sum_o (squared_error_sum_o),
  .mse_value_o         (mse_value_o),
  .psnr_db_o           (psnr_db_o),
  .psnr_infinite_o     (psnr_infinite_o)
);
